// ===== hw/rtl/murm_pkg.sv =====
// ----------------------------------------------------------------------------
// murm_pkg: shared types and constants for the MurmurHash3 x64 128 unit
// Mix constants, multiplier constant select, sequencer states and the
// control structs between the sequencer and the shared multiplier.
// ----------------------------------------------------------------------------
package murm_pkg;

    // Mix and finalizer constants
    localparam logic [63:0] MIX_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FIN_M1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_M2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] ADD_1  = 64'h0000000052dce729;
    localparam logic [63:0] ADD_2  = 64'h0000000038495ab5;

    // Full block byte count
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    // Constant operand of the shared multiplier
    typedef enum logic [1:0] {
        K_C1,
        K_C2,
        K_M1,
        K_M2
    } murm_const_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_K1A,
        ST_K1B,
        ST_H1R,
        ST_H1M,
        ST_H1A,
        ST_K2A,
        ST_K2B,
        ST_H2R,
        ST_H2M,
        ST_H2A,
        ST_T2A,
        ST_T2B,
        ST_T1A,
        ST_T1B,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2,
        ST_F1A,
        ST_F1B,
        ST_F1C,
        ST_F2B,
        ST_F2C,
        ST_FIN3,
        ST_FIN4
    } murm_state_t;

    // Request from the sequencer to the multiplier
    typedef struct packed {
        logic        start;
        murm_const_t csel;
    } murm_mul_req_t;

    // Status from the multiplier to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } murm_mul_sts_t;

    // Look up the 64-bit constant for a select code
    function automatic logic [63:0] mul_const(murm_const_t sel);
        logic [63:0] val;
        case (sel)
            K_C1:    val = MIX_C1;
            K_C2:    val = MIX_C2;
            K_M1:    val = FIN_M1;
            K_M2:    val = FIN_M2;
            default: val = MIX_C1;
        endcase
        return val;
    endfunction

    // Reverse the eight bytes of a word
    function automatic logic [63:0] swap_bytes(logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/murm_if.sv =====
// ----------------------------------------------------------------------------
// murm_if: stream channels of the hash unit
// murm_in_if carries message blocks, murm_out_if carries finished hashes.
// ----------------------------------------------------------------------------
interface murm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic [4:0]  byte_count;
    logic        last;

    modport source (output valid, output word_low, output word_high,
                    output byte_count, output last, input ready);
    modport sink   (input valid, input word_low, input word_high,
                    input byte_count, input last, output ready);
endinterface

interface murm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_first;
    logic [63:0] hash_second;

    modport source (output valid, output hash_first, output hash_second, input ready);
    modport sink   (input valid, input hash_first, input hash_second, output ready);
endinterface

// ===== hw/rtl/murm_mul.sv =====
// ----------------------------------------------------------------------------
// murm_mul: shared 64 x 64 constant multiplier, low 64 bits of the product
// One 32 x 32 multiplier walks three partial products in turn;
// done pulses for one cycle when the product register holds the result.
// ----------------------------------------------------------------------------
module murm_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  murm_pkg::murm_mul_req_t req,
    input  logic [63:0]            opnd,
    output murm_pkg::murm_mul_sts_t sts,
    output logic [63:0]            prod
);
    import murm_pkg::*;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] pp;

    // Select partial product operands: lo*lo, hi*lo, lo*hi
    always_comb
    begin
        case (phase_reg)
            2'd0:    mx = a_reg[31:0];
            2'd1:    mx = a_reg[63:32];
            default: mx = a_reg[31:0];
        endcase
        my = (phase_reg == 2'd2) ? b_reg[63:32] : b_reg[31:0];
        pp = {32'b0, mx} * {32'b0, my};
    end

    // Advance the phase counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (phase_reg == 2'd2);
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 2'd0;
                end
            end
            else if (phase_reg == 2'd2)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    // Latch operands and accumulate partial products
    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            a_reg <= opnd;
            b_reg <= mul_const(req.csel);
        end
        if (busy_reg)
        begin
            if (phase_reg == 2'd0)
            begin
                prod_reg <= pp;
            end
            else
            begin
                prod_reg[63:32] <= prod_reg[63:32] + pp[31:0];
            end
        end
    end

    assign prod     = prod_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ===== hw/rtl/murm_core.sv =====
// ----------------------------------------------------------------------------
// murm_core: hash sequencer and running state
// Takes one block at a time and steps body mix, tail mix and finalizer
// through the shared multiplier, with xor, rotate and add steps between.
// ----------------------------------------------------------------------------
module murm_core (
    input  logic                    clk,
    input  logic                    rst_n,
    murm_in_if.sink                 msg,
    input  logic [31:0]             seed,
    input  logic                    res_free,
    output logic                    res_load,
    output logic [63:0]             res_first,
    output logic [63:0]             res_second,
    output murm_pkg::murm_mul_req_t mul_req,
    output logic [63:0]             mul_opnd,
    input  murm_pkg::murm_mul_sts_t mul_sts,
    input  logic [63:0]             mul_prod
);
    import murm_pkg::*;

    murm_state_t state_reg, state_next;
    logic        mid_reg, mid_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] hi_reg, hi_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic        full_reg, full_next;

    logic [4:0]  cnt_sat;
    logic [3:0]  tail_n;
    logic [63:0] lo_tail;
    logic [63:0] hi_tail;
    logic [63:0] p_rot31;
    logic [63:0] p_rot33;
    logic [63:0] p_fold;
    logic [63:0] h1_fold;
    logic [63:0] h2_fold;
    logic [63:0] h2_sum;

    // Clamp the incoming count to one block
    assign cnt_sat = msg.byte_count[4] ? BLOCK_BYTES : msg.byte_count;

    // Mask tail bytes beyond the count
    assign tail_n = cnt_reg[3:0];
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lo_tail[8*i +: 8] = (4'(i) < tail_n) ? lo_reg[8*i +: 8] : 8'h00;
            hi_tail[8*i +: 8] = (4'(i + 8) < tail_n) ? hi_reg[8*i +: 8] : 8'h00;
        end
    end

    // Rotations and shift folds of the product and running words
    assign p_rot31 = {mul_prod[32:0], mul_prod[63:33]};
    assign p_rot33 = {mul_prod[30:0], mul_prod[63:31]};
    assign p_fold  = mul_prod ^ {33'b0, mul_prod[63:33]};
    assign h1_fold = h1_reg ^ {33'b0, h1_reg[63:33]};
    assign h2_fold = h2_reg ^ {33'b0, h2_reg[63:33]};
    assign h2_sum  = h2_reg + h1_reg;

    assign msg.ready  = (state_reg == ST_IDLE);
    assign res_first  = h1_reg;
    assign res_second = h2_sum;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (full_reg)
                begin
                    state_next = ST_K1A;
                end
                else if (tail_n > 4'd8)
                begin
                    state_next = ST_T2A;
                end
                else if (tail_n != 4'd0)
                begin
                    state_next = ST_T1A;
                end
                else
                begin
                    state_next = ST_FIN0;
                end
            end
            ST_K1A: if (mul_sts.done) state_next = ST_K1B;
            ST_K1B: if (mul_sts.done) state_next = ST_H1R;
            ST_H1R: state_next = ST_H1M;
            ST_H1M: state_next = ST_H1A;
            ST_H1A: state_next = ST_K2A;
            ST_K2A: if (mul_sts.done) state_next = ST_K2B;
            ST_K2B: if (mul_sts.done) state_next = ST_H2R;
            ST_H2R: state_next = ST_H2M;
            ST_H2M: state_next = ST_H2A;
            ST_H2A: state_next = last_reg ? ST_FIN0 : ST_IDLE;
            ST_T2A: if (mul_sts.done) state_next = ST_T2B;
            ST_T2B: if (mul_sts.done) state_next = ST_T1A;
            ST_T1A: if (mul_sts.done) state_next = ST_T1B;
            ST_T1B: if (mul_sts.done) state_next = ST_FIN0;
            ST_FIN0: state_next = ST_FIN1;
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_F1A;
            ST_F1A: state_next = ST_F1B;
            ST_F1B: if (mul_sts.done) state_next = ST_F1C;
            ST_F1C: if (mul_sts.done) state_next = ST_F2B;
            ST_F2B: if (mul_sts.done) state_next = ST_F2C;
            ST_F2C: if (mul_sts.done) state_next = ST_FIN3;
            ST_FIN3: state_next = ST_FIN4;
            ST_FIN4: if (res_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and multiplier requests
    always_comb
    begin
        mid_next     = mid_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        len_next     = len_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        full_next    = full_reg;
        mul_req      = '{start: 1'b0, csel: K_C1};
        mul_opnd     = lo_reg;
        res_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // Capture the block; reload seed at message start
                if (msg.valid)
                begin
                    lo_next   = msg.word_low;
                    hi_next   = msg.word_high;
                    cnt_next  = cnt_sat;
                    last_next = msg.last;
                    full_next = !msg.last || (cnt_sat == BLOCK_BYTES);
                    len_next  = (mid_reg ? len_reg : 64'd0) +
                                (msg.last ? {59'b0, cnt_sat} : {59'b0, BLOCK_BYTES});
                    if (!mid_reg)
                    begin
                        h1_next = {32'b0, seed};
                        h2_next = {32'b0, seed};
                    end
                end
            end
            ST_LOAD:
            begin
                if (full_reg)
                begin
                    mul_req  = '{start: 1'b1, csel: K_C1};
                    mul_opnd = lo_reg;
                end
                else if (tail_n > 4'd8)
                begin
                    mul_req  = '{start: 1'b1, csel: K_C2};
                    mul_opnd = hi_tail;
                end
                else if (tail_n != 4'd0)
                begin
                    mul_req  = '{start: 1'b1, csel: K_C1};
                    mul_opnd = lo_tail;
                end
            end
            // Body lane one, then fold into h1
            ST_K1A:
            begin
                mul_req  = '{start: mul_sts.done, csel: K_C2};
                mul_opnd = p_rot31;
            end
            ST_K1B: if (mul_sts.done) h1_next = h1_reg ^ mul_prod;
            ST_H1R: h1_next = {h1_reg[36:0], h1_reg[63:37]} + h2_reg;
            ST_H1M: h1_next = {h1_reg[61:0], 2'b00} + h1_reg;
            ST_H1A:
            begin
                h1_next  = h1_reg + ADD_1;
                mul_req  = '{start: 1'b1, csel: K_C2};
                mul_opnd = hi_reg;
            end
            // Body lane two, then fold into h2
            ST_K2A:
            begin
                mul_req  = '{start: mul_sts.done, csel: K_C1};
                mul_opnd = p_rot33;
            end
            ST_K2B: if (mul_sts.done) h2_next = h2_reg ^ mul_prod;
            ST_H2R: h2_next = {h2_reg[32:0], h2_reg[63:33]} + h1_reg;
            ST_H2M: h2_next = {h2_reg[61:0], 2'b00} + h2_reg;
            ST_H2A:
            begin
                h2_next = h2_reg + ADD_2;
                if (!last_reg)
                begin
                    mid_next = 1'b1;
                end
            end
            // Tail lanes
            ST_T2A:
            begin
                mul_req  = '{start: mul_sts.done, csel: K_C1};
                mul_opnd = p_rot33;
            end
            ST_T2B:
            begin
                if (mul_sts.done)
                begin
                    h2_next = h2_reg ^ mul_prod;
                end
                mul_req  = '{start: mul_sts.done, csel: K_C1};
                mul_opnd = lo_tail;
            end
            ST_T1A:
            begin
                mul_req  = '{start: mul_sts.done, csel: K_C2};
                mul_opnd = p_rot31;
            end
            ST_T1B: if (mul_sts.done) h1_next = h1_reg ^ mul_prod;
            // Finalize: length, cross adds, fmix64 on each word
            ST_FIN0:
            begin
                h1_next = h1_reg ^ len_reg;
                h2_next = h2_reg ^ len_reg;
            end
            ST_FIN1: h1_next = h1_reg + h2_reg;
            ST_FIN2: h2_next = h2_sum;
            ST_F1A:
            begin
                mul_req  = '{start: 1'b1, csel: K_M1};
                mul_opnd = h1_fold;
            end
            ST_F1B:
            begin
                mul_req  = '{start: mul_sts.done, csel: K_M2};
                mul_opnd = p_fold;
            end
            ST_F1C:
            begin
                if (mul_sts.done)
                begin
                    h1_next = p_fold;
                end
                mul_req  = '{start: mul_sts.done, csel: K_M1};
                mul_opnd = h2_fold;
            end
            ST_F2B:
            begin
                mul_req  = '{start: mul_sts.done, csel: K_M2};
                mul_opnd = p_fold;
            end
            ST_F2C: if (mul_sts.done) h2_next = p_fold;
            ST_FIN3: h1_next = h1_reg + h2_reg;
            ST_FIN4:
            begin
                // Hand the result over once the output stage is free
                if (res_free)
                begin
                    res_load = 1'b1;
                    h2_next  = h2_sum;
                    mid_next = 1'b0;
                end
            end
            default:
            begin
                mid_next = mid_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mid_reg   <= mid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        h1_reg   <= h1_next;
        h2_reg   <= h2_next;
        len_reg  <= len_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        full_reg <= full_next;
    end

endmodule

// ===== hw/rtl/murmur3_x64_128_hash_unit.sv =====
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash_unit: MurmurHash3 x64 128-bit streaming hash
// Seed register, sequencer with shared multiplier and output stage.
// ----------------------------------------------------------------------------
// Each multiply runs 3 partial products in turn through the shared 32 x 32
// multiplier; the multiply chain sets the rate.
// One block at a time: a new block is taken only once the last one is through.
// A last block runs the body mix (16 bytes) or the tail lanes its count needs,
// then the finalizer; ready returns in the cycle after the result loads.
// Reset clears seed to zero, empties the output stage and starts a new message.
module murmur3_x64_128_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data,
    murm_in_if.sink     msg,
    murm_out_if.source  hash
);
    import murm_pkg::*;

    logic [31:0]   seed_reg;
    logic          hash_valid_reg;
    logic [63:0]   hash_first_reg;
    logic [63:0]   hash_second_reg;
    logic          res_free;
    logic          res_load;
    logic [63:0]   res_first;
    logic [63:0]   res_second;
    murm_mul_req_t mul_req;
    murm_mul_sts_t mul_sts;
    logic [63:0]   mul_opnd;
    logic [63:0]   mul_prod;

    // Hold the seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
        end
        else if (seed_wr_en)
        begin
            seed_reg <= seed_wr_data;
        end
    end

    // Sequencer and running state
    murm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .seed       (seed_reg),
        .res_free   (res_free),
        .res_load   (res_load),
        .res_first  (res_first),
        .res_second (res_second),
        .mul_req    (mul_req),
        .mul_opnd   (mul_opnd),
        .mul_sts    (mul_sts),
        .mul_prod   (mul_prod)
    );

    // Shared multiplier
    murm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .opnd  (mul_opnd),
        .sts   (mul_sts),
        .prod  (mul_prod)
    );

    // Output stage: free when empty or when the held beat leaves
    assign res_free = !hash_valid_reg || hash.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            hash_valid_reg <= 1'b1;
        end
        else if (hash.ready)
        begin
            hash_valid_reg <= 1'b0;
        end
    end

    // Load byte-swapped hash words
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            hash_first_reg  <= swap_bytes(res_first);
            hash_second_reg <= swap_bytes(res_second);
        end
    end

    assign hash.valid       = hash_valid_reg;
    assign hash.hash_first  = hash_first_reg;
    assign hash.hash_second = hash_second_reg;

    // A new block is taken only while the multiplier is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !mul_sts.busy)
        else $error("block accepted while multiplier busy");

    // Multiplier completions are single-cycle pulses
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.done |=> !mul_sts.done)
        else $error("multiplier done held for two cycles");

    // A result never overwrites a pending beat
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!hash_valid_reg || hash.ready))
        else $error("result loaded over a pending beat");

    // The sequencer never starts a multiply while one is running
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.busy |-> !mul_req.start)
        else $error("multiply started while busy");

endmodule

// ===== sim/tb_murmur3_x64_128_hash_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_murmur3_x64_128_hash_unit: self-checking bench for the 128-bit hash unit
// Streams messages of random length and content under several seeds. An
// in-bench model folds each accepted block and queues the expected digest,
// and the output monitor checks every digest against it. Both channels stall
// at random, and the output side also holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_murmur3_x64_128_hash_unit;

    import murm_pkg::*;

    // Mix constants, kept local to the model
    localparam bit [63:0] LANE1_MUL = 64'h87c37b91114253d5;
    localparam bit [63:0] LANE2_MUL = 64'h4cf5ad432745937f;
    localparam bit [63:0] AVAL_MUL1 = 64'hff51afd7ed558ccd;
    localparam bit [63:0] AVAL_MUL2 = 64'hc4ceb9fe1a85ec53;
    localparam bit [63:0] H1_BIAS   = 64'h0000000052dce729;
    localparam bit [63:0] H2_BIAS   = 64'h0000000038495ab5;

    localparam int FULL_BLOCK       = 16;
    localparam int MAX_GAP          = 5;
    localparam int SETTLE_CYCLES    = 64;
    localparam int LONG_HOLD_EVERY  = 250;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT      = 3000;
    localparam int PHASE_BLOCKS     = 385;

    typedef struct packed {
        bit [63:0] word_low;
        bit [63:0] word_high;
        bit [4:0]  byte_count;
        bit        last;
    } block_t;

    typedef struct packed {
        bit [63:0] hash_first;
        bit [63:0] hash_second;
    } digest_t;

    logic clk;
    logic rst_n;
    logic        seed_wr_en;
    logic [31:0] seed_wr_data;

    murm_in_if  msg_ch ();
    murm_out_if hash_ch ();

    murmur3_x64_128_hash_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .msg          (msg_ch),
        .hash         (hash_ch)
    );

    // Stimulus and expectation stores
    block_t  pending_blocks[$];
    digest_t expected_digests[$];
    block_t  cur_block;
    bit      holding;
    bit      no_gaps;
    int      send_gap;
    int      recv_stall;
    int      blocks_accepted;
    int      digests_seen;
    int      seed_settings;
    int      quiet_cycles;
    int      errors;

    // Hash model state
    bit [31:0] seed_model;
    bit [63:0] run_h1;
    bit [63:0] run_h2;
    bit [63:0] msg_len;
    bit        in_message;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Hash model
    // ------------------------------------------------------------------
    function automatic bit [63:0] rotl64(bit [63:0] x, int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic bit [63:0] scramble_low(bit [63:0] k);
        k = k * LANE1_MUL;
        k = rotl64(k, 31);
        return k * LANE2_MUL;
    endfunction

    function automatic bit [63:0] scramble_high(bit [63:0] k);
        k = k * LANE2_MUL;
        k = rotl64(k, 33);
        return k * LANE1_MUL;
    endfunction

    function automatic bit [63:0] avalanche(bit [63:0] k);
        k = k ^ (k >> 33);
        k = k * AVAL_MUL1;
        k = k ^ (k >> 33);
        k = k * AVAL_MUL2;
        k = k ^ (k >> 33);
        return k;
    endfunction

    function automatic bit [63:0] reverse_bytes(bit [63:0] x);
        bit [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    // Keep the low n bytes of a word, n in 0..8
    function automatic bit [63:0] low_bytes(bit [63:0] w, int n);
        if (n >= 8)
            return w;
        return w & ((64'h1 << (8 * n)) - 64'h1);
    endfunction

    task automatic mix_full(input bit [63:0] k1, input bit [63:0] k2);
        bit [63:0] a;
        bit [63:0] c;
        a = run_h1;
        c = run_h2;
        a = a ^ scramble_low(k1);
        a = rotl64(a, 27);
        a = a + c;
        a = a * 64'd5 + H1_BIAS;
        c = c ^ scramble_high(k2);
        c = rotl64(c, 31);
        c = c + a;
        c = c * 64'd5 + H2_BIAS;
        run_h1 = a;
        run_h2 = c;
    endtask

    // Fold one accepted block; a last block yields the message digest
    task automatic fold_block(input block_t b, output bit produced, output digest_t d);
        int n;
        bit [63:0] a;
        bit [63:0] c;
        n = (b.byte_count > FULL_BLOCK) ? FULL_BLOCK : int'(b.byte_count);
        produced = 1'b0;
        d = '0;
        if (!in_message)
        begin
            run_h1 = {32'b0, seed_model};
            run_h2 = {32'b0, seed_model};
            msg_len = '0;
        end
        if (!b.last)
        begin
            mix_full(b.word_low, b.word_high);
            msg_len = msg_len + FULL_BLOCK;
            in_message = 1'b1;
        end
        else
        begin
            if (n == FULL_BLOCK)
                mix_full(b.word_low, b.word_high);
            else
            begin
                if (n > 8)
                    run_h2 = run_h2 ^ scramble_high(low_bytes(b.word_high, n - 8));
                if (n >= 1)
                    run_h1 = run_h1 ^ scramble_low(low_bytes(b.word_low, n));
            end
            msg_len = msg_len + n;
            a = run_h1 ^ msg_len;
            c = run_h2 ^ msg_len;
            a = a + c;
            c = c + a;
            a = avalanche(a);
            c = avalanche(c);
            a = a + c;
            c = c + a;
            run_h1 = a;
            run_h2 = c;
            in_message = 1'b0;
            produced = 1'b1;
            d.hash_first = reverse_bytes(a);
            d.hash_second = reverse_bytes(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: present queued blocks with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_blocks
        bit offer;
        bit produced;
        digest_t d;
        if (!rst_n)
        begin
            msg_ch.valid      <= 1'b0;
            msg_ch.word_low   <= '0;
            msg_ch.word_high  <= '0;
            msg_ch.byte_count <= '0;
            msg_ch.last       <= 1'b0;
            holding = 1'b0;
            send_gap = 0;
        end
        else
        begin
            offer = msg_ch.valid;
            // Fold the accepted beat and draw the next gap
            if (msg_ch.valid && msg_ch.ready)
            begin
                fold_block(cur_block, produced, d);
                if (produced)
                    expected_digests.push_back(d);
                blocks_accepted++;
                offer = 1'b0;
                holding = 1'b0;
                send_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            // Advance to the next block once the gap has run out
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_blocks.size() > 0)
                begin
                    cur_block = pending_blocks.pop_front();
                    offer = 1'b1;
                    holding = 1'b1;
                end
            end
            msg_ch.valid      <= offer;
            msg_ch.word_low   <= cur_block.word_low;
            msg_ch.word_high  <= cur_block.word_high;
            msg_ch.byte_count <= cur_block.byte_count;
            msg_ch.last       <= cur_block.last;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: check each digest beat, stall ready at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : collect_digests
        digest_t want;
        bit rdy;
        if (!rst_n)
        begin
            hash_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (hash_ch.valid && hash_ch.ready)
            begin
                digests_seen++;
                if (expected_digests.size() == 0)
                begin
                    $error("unexpected digest: hash_first %h, hash_second %h",
                           hash_ch.hash_first, hash_ch.hash_second);
                    errors++;
                end
                else
                begin
                    want = expected_digests.pop_front();
                    if (hash_ch.hash_first !== want.hash_first)
                    begin
                        $error("hash_first mismatch: expected %h, actual %h",
                               want.hash_first, hash_ch.hash_first);
                        errors++;
                    end
                    if (hash_ch.hash_second !== want.hash_second)
                    begin
                        $error("hash_second mismatch: expected %h, actual %h",
                               want.hash_second, hash_ch.hash_second);
                        errors++;
                    end
                end
                // Hold off for a long stretch now and then to back up the input
                if (digests_seen % LONG_HOLD_EVERY == 0)
                    recv_stall = LONG_HOLD_CYCLES;
                else
                    recv_stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            rdy = (recv_stall == 0);
            if (recv_stall > 0)
                recv_stall--;
            hash_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when neither channel moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_ch.valid && msg_ch.ready) || (hash_ch.valid && hash_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic wait_idle();
        while (pending_blocks.size() != 0 || holding || expected_digests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input bit [31:0] s);
        @(posedge clk);
        seed_wr_en   <= 1'b1;
        seed_wr_data <= s;
        @(posedge clk);
        seed_wr_en   <= 1'b0;
        seed_model = s;
        seed_settings++;
    endtask

    task automatic push_block(input bit [63:0] lo, input bit [63:0] hi,
                              input int cnt, input bit is_last);
        block_t b;
        b.word_low   = lo;
        b.word_high  = hi;
        b.byte_count = 5'(cnt);
        b.last       = is_last;
        pending_blocks.push_back(b);
    endtask

    function automatic bit [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Queue one message; noisy messages carry junk counts on body blocks
    // and, sometimes, an oversized count on the last block
    task automatic queue_message(input int full_blocks, input bit noisy);
        int cnt;
        for (int i = 0; i < full_blocks; i++)
        begin
            cnt = noisy ? $urandom_range(0, 31) : FULL_BLOCK;
            push_block(rand_word(), rand_word(), cnt, 1'b0);
        end
        if (noisy && $urandom_range(0, 1))
            cnt = $urandom_range(FULL_BLOCK + 1, 31);
        else
            cnt = $urandom_range(0, FULL_BLOCK);
        push_block(rand_word(), rand_word(), cnt, 1'b1);
    endtask

    task automatic run_phase(input bit [31:0] s, input int target, input bit calm);
        int queued;
        int pick;
        int nblk;
        queued = 0;
        wait_idle();
        write_seed(s);
        no_gaps = calm;
        while (queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                nblk = 0;
            else if (pick < 85)
                nblk = $urandom_range(1, 3);
            else if (pick < 98)
                nblk = $urandom_range(4, 8);
            else
                nblk = $urandom_range(16, 32);
            queue_message(nblk, $urandom_range(0, 9) == 0);
            queued += nblk + 1;
        end
        wait_idle();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        seed_wr_en = 1'b0;
        seed_wr_data = '0;
        msg_ch.valid = 1'b0;
        msg_ch.word_low = '0;
        msg_ch.word_high = '0;
        msg_ch.byte_count = '0;
        msg_ch.last = 1'b0;
        hash_ch.ready = 1'b0;
        cur_block = '0;
        holding = 1'b0;
        no_gaps = 1'b0;
        send_gap = 0;
        recv_stall = 0;
        blocks_accepted = 0;
        digests_seen = 0;
        seed_settings = 0;
        quiet_cycles = 0;
        errors = 0;
        seed_model = '0;
        run_h1 = '0;
        run_h2 = '0;
        msg_len = '0;
        in_message = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, every tail length class, full last block,
        // oversized counts, ignored counts on body blocks, extreme words
        push_block(rand_word(), rand_word(), 0, 1'b1);
        push_block('1, '1, 1, 1'b1);
        push_block('1, '1, 8, 1'b1);
        push_block('1, '1, 9, 1'b1);
        push_block(rand_word(), rand_word(), 15, 1'b1);
        push_block('1, '1, FULL_BLOCK, 1'b1);
        push_block('0, '0, FULL_BLOCK, 1'b0);
        push_block('1, '1, 0, 1'b1);
        push_block('1, '1, 5, 1'b0);
        push_block(rand_word(), rand_word(), 17, 1'b1);
        push_block('1, '1, 31, 1'b1);
        push_block(rand_word(), rand_word(), 0, 1'b0);
        push_block(rand_word(), rand_word(), 12, 1'b1);
        push_block(rand_word(), rand_word(), FULL_BLOCK, 1'b0);
        push_block(rand_word(), rand_word(), FULL_BLOCK, 1'b0);
        push_block('0, '0, 0, 1'b1);

        // Random phases under extreme and random seeds; one runs without gaps
        run_phase(32'hffffffff, PHASE_BLOCKS, 1'b0);
        run_phase($urandom, PHASE_BLOCKS, 1'b0);
        run_phase(32'h00000000, PHASE_BLOCKS, 1'b1);
        run_phase($urandom, PHASE_BLOCKS, 1'b0);
        run_phase($urandom, PHASE_BLOCKS, 1'b0);

        wait_idle();
        if (expected_digests.size() != 0)
        begin
            $error("%0d digests never arrived", expected_digests.size());
            errors++;
        end

        $display("Hashed %0d blocks into %0d checked digests over %0d seed settings,",
                 blocks_accepted, digests_seen, seed_settings);
        $display("with random stalls on both sides and long output hold-offs.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
